@@ hdl/two_level_cache_fifo_tracker_macros.svh @@
// Assertion macros for the cache tag tracker checker.
`ifndef TWO_LEVEL_CACHE_FIFO_TRACKER_MACROS_SVH
`define TWO_LEVEL_CACHE_FIFO_TRACKER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TLC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tracker check failed");

// Next-cycle implication, disabled in reset.
`define TLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tracker check failed");

`endif

@@ hdl/tlc_pkg.sv @@
`timescale 1ns / 1ps
package tlc_pkg;

  localparam int L1_MAX_SET_BITS = 6;
  localparam int L1_MAX_WAYS     = 8;
  localparam int L2_MAX_SET_BITS = 8;
  localparam int L2_MAX_WAYS     = 16;
  localparam int ADDR_W          = 32;
  localparam int SIZE_W          = 7;

  localparam int L1_WAY_W  = $clog2(L1_MAX_WAYS);
  localparam int L2_WAY_W  = $clog2(L2_MAX_WAYS);
  localparam int L1_AW     = L1_MAX_SET_BITS + L1_WAY_W;
  localparam int L2_AW     = L2_MAX_SET_BITS + L2_WAY_W;
  localparam int TAG_DW    = ADDR_W + 1;
  localparam int CLR_W     = L2_AW;

  localparam logic [1:0] OP_FETCH  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_STORE  = 2'd2;
  localparam logic [1:0] OP_MODIFY = 2'd3;

  localparam logic [2:0] CFG_L1_SET_BITS   = 3'd0;
  localparam logic [2:0] CFG_L1_WAYS       = 3'd1;
  localparam logic [2:0] CFG_L1_BLOCK_BITS = 3'd2;
  localparam logic [2:0] CFG_L2_SET_BITS   = 3'd3;
  localparam logic [2:0] CFG_L2_WAYS       = 3'd4;
  localparam logic [2:0] CFG_L2_BLOCK_BITS = 3'd5;

  typedef struct packed {
    logic [2:0] s1;
    logic [3:0] e1;
    logic [2:0] b1;
    logic [3:0] s2;
    logic [4:0] e2;
    logic [2:0] b2;
  } cfg_t;

  typedef struct packed {
    logic [L1_MAX_SET_BITS-1:0] set1;
    logic [L2_MAX_SET_BITS-1:0] set2;
    logic [ADDR_W-1:0]          tag1;
    logic [ADDR_W-1:0]          tag2;
    logic                       fit_err;
  } split_t;

  function automatic cfg_t clamp_cfg(logic [2:0] s1, logic [3:0] e1, logic [2:0] b1,
                                     logic [3:0] s2, logic [4:0] e2, logic [2:0] b2);
    cfg_t c;
    c.s1 = (s1 > 3'd6) ? 3'd6 : s1;
    c.e1 = (e1 == 4'd0) ? 4'd1 : ((e1 > 4'd8) ? 4'd8 : e1);
    c.b1 = (b1 > 3'd6) ? 3'd6 : b1;
    c.s2 = (s2 > 4'd8) ? 4'd8 : s2;
    c.e2 = (e2 == 5'd0) ? 5'd1 : ((e2 > 5'd16) ? 5'd16 : e2);
    c.b2 = (b2 > 3'd6) ? 3'd6 : b2;
    return c;
  endfunction

endpackage

@@ hdl/tlc_if.sv @@
`timescale 1ns / 1ps
interface tlc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] address;
  logic [6:0]  access_size;

  modport source (output valid, op, address, access_size, input ready);
  modport sink (input valid, op, address, access_size, output ready);
endinterface

interface tlc_out_if;
  logic       valid;
  logic       ready;
  logic       l1_hit;
  logic       l2_hit;
  logic       l1_evicted;
  logic       l2_evicted;
  logic       fit_error;
  logic [5:0] l1_set_index;
  logic [7:0] l2_set_index;
  logic       store_part;
  logic       last_of_access;

  modport source (output valid, l1_hit, l2_hit, l1_evicted, l2_evicted, fit_error,
                  l1_set_index, l2_set_index, store_part, last_of_access, input ready);
  modport sink (input valid, l1_hit, l2_hit, l1_evicted, l2_evicted, fit_error,
                l1_set_index, l2_set_index, store_part, last_of_access, output ready);
endinterface

@@ hdl/tlc_ram.sv @@
`timescale 1ns / 1ps
module tlc_ram #(
  parameter int AW = 4,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ hdl/tlc_split.sv @@
`timescale 1ns / 1ps
module tlc_split (
  input  tlc_pkg::cfg_t          cfg_i,
  input  logic [31:0]            address_i,
  input  logic [6:0]             size_i,
  output tlc_pkg::split_t        split_o
);
  import tlc_pkg::*;

  logic [ADDR_W-1:0] sh1, sh2;
  logic [ADDR_W-1:0] msk1, msk2;
  logic [3:0]        tsh1;
  logic [4:0]        tsh2;
  logic [6:0]        blk1, blk2;
  logic [5:0]        off1, off2;
  logic [7:0]        end1, end2;

  always_comb begin
    sh1  = address_i >> cfg_i.b1;
    sh2  = address_i >> cfg_i.b2;
    msk1 = (32'd1 << cfg_i.s1) - 32'd1;
    msk2 = (32'd1 << cfg_i.s2) - 32'd1;
    tsh1 = {1'b0, cfg_i.s1} + {1'b0, cfg_i.b1};
    tsh2 = {1'b0, cfg_i.s2} + {2'b0, cfg_i.b2};
    blk1 = 7'd1 << cfg_i.b1;
    blk2 = 7'd1 << cfg_i.b2;
    off1 = address_i[5:0] & (blk1[5:0] - 6'd1);
    off2 = address_i[5:0] & (blk2[5:0] - 6'd1);
    end1 = {2'b0, off1} + {1'b0, size_i};
    end2 = {2'b0, off2} + {1'b0, size_i};
    split_o.set1    = sh1[L1_MAX_SET_BITS-1:0] & msk1[L1_MAX_SET_BITS-1:0];
    split_o.set2    = sh2[L2_MAX_SET_BITS-1:0] & msk2[L2_MAX_SET_BITS-1:0];
    split_o.tag1    = address_i >> tsh1;
    split_o.tag2    = address_i >> tsh2;
    split_o.fit_err = (end1 > {1'b0, blk1}) || (end2 > {1'b0, blk2});
  end
endmodule

@@ hdl/two_level_cache_fifo_tracker.sv @@
// Channel | Dir | Handshake       | Beat
// acc_i   | in  | valid / ready   | op, address, access_size
// res_o   | out | valid / ready   | hit/evict/fit flags, set indices, store_part, last
// cfg     | in  | cfg_we_i        | cfg_idx_i selects the register, cfg_wdata_i value
//
// One part of an access runs split, then walks the L2 ways one RAM read and compare at
// a time with the single tag comparator, fills L2 on a miss, then does the same for L1
// and emits; a modify without a boundary crossing runs two parts, a crossing goes to emit.
// After reset a clearing pass wipes valid bits and victim pointers;
// no beat is accepted during it, configuration writes are.
// The result register lets the next access enter while the last beat waits.
`timescale 1ns / 1ps
module two_level_cache_fifo_tracker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [4:0]   cfg_wdata_i,
  tlc_in_if.sink       acc_i,
  tlc_out_if.source    res_o
);
  import tlc_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SPLIT = 4'd2;
  localparam logic [3:0] S_L2_RD = 4'd3;
  localparam logic [3:0] S_L2_CMP = 4'd4;
  localparam logic [3:0] S_L2_FILL = 4'd5;
  localparam logic [3:0] S_L1_RD = 4'd6;
  localparam logic [3:0] S_L1_CMP = 4'd7;
  localparam logic [3:0] S_L1_FILL = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  // Configuration registers, raw as written.
  logic [2:0] l1_set_bits_q, l1_block_bits_q, l2_block_bits_q;
  logic [3:0] l1_ways_q, l2_set_bits_q;
  logic [4:0] l2_ways_q;
  cfg_t       cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_set_bits_q   <= 3'd2;
      l1_ways_q       <= 4'd2;
      l1_block_bits_q <= 3'd4;
      l2_set_bits_q   <= 4'd4;
      l2_ways_q       <= 5'd4;
      l2_block_bits_q <= 3'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_L1_SET_BITS:   l1_set_bits_q   <= cfg_wdata_i[2:0];
        CFG_L1_WAYS:       l1_ways_q       <= cfg_wdata_i[3:0];
        CFG_L1_BLOCK_BITS: l1_block_bits_q <= cfg_wdata_i[2:0];
        CFG_L2_SET_BITS:   l2_set_bits_q   <= cfg_wdata_i[3:0];
        CFG_L2_WAYS:       l2_ways_q       <= cfg_wdata_i;
        CFG_L2_BLOCK_BITS: l2_block_bits_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign cfg = clamp_cfg(l1_set_bits_q, l1_ways_q, l1_block_bits_q,
                         l2_set_bits_q, l2_ways_q, l2_block_bits_q);

  // Sequencer state.
  logic [3:0]        state_q, state_d;
  logic [CLR_W-1:0]  clr_q, clr_d;
  logic [1:0]        op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SIZE_W-1:0] size_q;
  logic              part_q, part_d;
  logic [L2_WAY_W-1:0] way_q, way_d, fway_q, fway_d;
  logic              fnd_q, fnd_d;
  logic              l1hit_q, l1hit_d, l2hit_q, l2hit_d;
  logic              l1ev_q, l1ev_d, l2ev_q, l2ev_d, fit_q, fit_d;
  split_t            sp;

  tlc_split u_split (
    .cfg_i    (cfg),
    .address_i(addr_q),
    .size_i   (size_q),
    .split_o  (sp)
  );

  // Tag and victim stores.
  logic                clearing, instr, lvl2;
  logic [TAG_DW-1:0]   l2_rd, l1i_rd, l1d_rd, cmp_rd;
  logic [L2_WAY_W-1:0] vic2_rd;
  logic [L1_WAY_W-1:0] vic1i_rd, vic1d_rd;
  logic [L2_WAY_W-1:0] vic_cur, pick, vic_nxt;
  logic [4:0]          ways_cur, way_inc, pick_inc;
  logic [ADDR_W-1:0]   tag_cur;
  logic                cmp_hit;
  logic                fill2, fill1;
  logic [L2_AW-1:0]    l2_waddr;
  logic [L1_AW-1:0]    l1_waddr;
  logic [TAG_DW-1:0]   l2_wdata, l1_wdata;
  logic [L2_MAX_SET_BITS-1:0] vic2_waddr;
  logic [L1_MAX_SET_BITS-1:0] vic1_waddr;
  logic [L2_WAY_W-1:0] vic2_wdata;
  logic [L1_WAY_W-1:0] vic1_wdata;

  assign clearing = (state_q == S_CLEAR);
  assign instr    = (op_q == OP_FETCH);
  assign lvl2     = (state_q == S_L2_RD) || (state_q == S_L2_CMP) || (state_q == S_L2_FILL);
  assign fill2    = (state_q == S_L2_FILL);
  assign fill1    = (state_q == S_L1_FILL);

  // The shared comparator: whichever level is being probed.
  assign cmp_rd   = lvl2 ? l2_rd : (instr ? l1i_rd : l1d_rd);
  assign tag_cur  = lvl2 ? sp.tag2 : sp.tag1;
  assign cmp_hit  = cmp_rd[TAG_DW-1] && (cmp_rd[ADDR_W-1:0] == tag_cur);
  assign ways_cur = lvl2 ? cfg.e2 : {1'b0, cfg.e1};
  assign way_inc  = {1'b0, way_q} + 5'd1;
  assign vic_cur  = lvl2 ? vic2_rd : {1'b0, (instr ? vic1i_rd : vic1d_rd)};

  // Lowest free way wins; otherwise the pointer, pulled back to 0 when out of range.
  always_comb begin
    if (fnd_q) begin
      pick = fway_q;
    end else if ({1'b0, vic_cur} >= ways_cur) begin
      pick = '0;
    end else begin
      pick = vic_cur;
    end
    pick_inc = {1'b0, pick} + 5'd1;
    vic_nxt  = (pick_inc >= ways_cur) ? '0 : pick_inc[L2_WAY_W-1:0];
  end

  assign l2_waddr   = clearing ? clr_q : {sp.set2, pick};
  assign l2_wdata   = clearing ? '0 : {1'b1, sp.tag2};
  assign l1_waddr   = clearing ? clr_q[L1_AW-1:0] : {sp.set1, pick[L1_WAY_W-1:0]};
  assign l1_wdata   = clearing ? '0 : {1'b1, sp.tag1};
  assign vic2_waddr = clearing ? clr_q[L2_MAX_SET_BITS-1:0] : sp.set2;
  assign vic1_waddr = clearing ? clr_q[L1_MAX_SET_BITS-1:0] : sp.set1;
  assign vic2_wdata = clearing ? '0 : vic_nxt;
  assign vic1_wdata = clearing ? '0 : vic_nxt[L1_WAY_W-1:0];

  tlc_ram #(.AW(L2_AW), .DW(TAG_DW)) u_l2_tag (
    .clk_i, .we_i(clearing || fill2), .waddr_i(l2_waddr), .wdata_i(l2_wdata),
    .raddr_i({sp.set2, way_q}), .rdata_o(l2_rd)
  );
  tlc_ram #(.AW(L1_AW), .DW(TAG_DW)) u_l1i_tag (
    .clk_i, .we_i(clearing || (fill1 && instr)), .waddr_i(l1_waddr), .wdata_i(l1_wdata),
    .raddr_i({sp.set1, way_q[L1_WAY_W-1:0]}), .rdata_o(l1i_rd)
  );
  tlc_ram #(.AW(L1_AW), .DW(TAG_DW)) u_l1d_tag (
    .clk_i, .we_i(clearing || (fill1 && !instr)), .waddr_i(l1_waddr), .wdata_i(l1_wdata),
    .raddr_i({sp.set1, way_q[L1_WAY_W-1:0]}), .rdata_o(l1d_rd)
  );
  tlc_ram #(.AW(L2_MAX_SET_BITS), .DW(L2_WAY_W)) u_l2_vic (
    .clk_i, .we_i(clearing || fill2), .waddr_i(vic2_waddr), .wdata_i(vic2_wdata),
    .raddr_i(sp.set2), .rdata_o(vic2_rd)
  );
  tlc_ram #(.AW(L1_MAX_SET_BITS), .DW(L1_WAY_W)) u_l1i_vic (
    .clk_i, .we_i(clearing || (fill1 && instr)), .waddr_i(vic1_waddr),
    .wdata_i(vic1_wdata), .raddr_i(sp.set1), .rdata_o(vic1i_rd)
  );
  tlc_ram #(.AW(L1_MAX_SET_BITS), .DW(L1_WAY_W)) u_l1d_vic (
    .clk_i, .we_i(clearing || (fill1 && !instr)), .waddr_i(vic1_waddr),
    .wdata_i(vic1_wdata), .raddr_i(sp.set1), .rdata_o(vic1d_rd)
  );

  // Result register.
  logic out_free, emit, acc_fire;
  logic res_valid_q;

  assign acc_i.ready = (state_q == S_IDLE);
  assign acc_fire    = acc_i.valid && acc_i.ready;
  assign out_free    = !res_valid_q || res_o.ready;
  assign emit        = (state_q == S_EMIT) && out_free;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    part_d  = part_q;
    way_d   = way_q;
    fway_d  = fway_q;
    fnd_d   = fnd_q;
    l1hit_d = l1hit_q;
    l2hit_d = l2hit_q;
    l1ev_d  = l1ev_q;
    l2ev_d  = l2ev_q;
    fit_d   = fit_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (acc_fire) begin
          part_d  = 1'b0;
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        // Boundary crossing: report and leave all stores alone.
        fit_d   = sp.fit_err;
        l1hit_d = 1'b0;
        l2hit_d = 1'b0;
        l1ev_d  = 1'b0;
        l2ev_d  = 1'b0;
        way_d   = '0;
        fnd_d   = 1'b0;
        state_d = sp.fit_err ? S_EMIT : S_L2_RD;
      end
      S_L2_RD, S_L1_RD: begin
        state_d = lvl2 ? S_L2_CMP : S_L1_CMP;
      end
      S_L2_CMP, S_L1_CMP: begin
        if (!fnd_q && !cmp_rd[TAG_DW-1]) begin
          fnd_d  = 1'b1;
          fway_d = way_q;
        end
        if (cmp_hit) begin
          if (lvl2) begin
            l2hit_d = 1'b1;
            way_d   = '0;
            fnd_d   = 1'b0;
            state_d = S_L1_RD;
          end else begin
            l1hit_d = 1'b1;
            state_d = S_EMIT;
          end
        end else if (way_inc < ways_cur) begin
          way_d   = way_inc[L2_WAY_W-1:0];
          state_d = lvl2 ? S_L2_RD : S_L1_RD;
        end else begin
          state_d = lvl2 ? S_L2_FILL : S_L1_FILL;
        end
      end
      S_L2_FILL: begin
        l2ev_d  = !fnd_q;
        way_d   = '0;
        fnd_d   = 1'b0;
        state_d = S_L1_RD;
      end
      S_L1_FILL: begin
        l1ev_d  = !fnd_q;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if ((op_q == OP_MODIFY) && !part_q && !fit_q) begin
            part_d  = 1'b1;
            l1hit_d = 1'b0;
            l2hit_d = 1'b0;
            l1ev_d  = 1'b0;
            l2ev_d  = 1'b0;
            way_d   = '0;
            fnd_d   = 1'b0;
            state_d = S_L2_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      part_q      <= 1'b0;
      way_q       <= '0;
      fway_q      <= '0;
      fnd_q       <= 1'b0;
      l1hit_q     <= 1'b0;
      l2hit_q     <= 1'b0;
      l1ev_q      <= 1'b0;
      l2ev_q      <= 1'b0;
      fit_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      part_q  <= part_d;
      way_q   <= way_d;
      fway_q  <= fway_d;
      fnd_q   <= fnd_d;
      l1hit_q <= l1hit_d;
      l2hit_q <= l2hit_d;
      l1ev_q  <= l1ev_d;
      l2ev_q  <= l2ev_d;
      fit_q   <= fit_d;
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Latch the access beat; no reset needed on payload.
  always_ff @(posedge clk_i) begin
    if (acc_fire) begin
      op_q   <= acc_i.op;
      addr_q <= acc_i.address;
      size_q <= acc_i.access_size;
    end
  end

  // Hold the result beat until it is taken.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_o.l1_hit         <= l1hit_q;
      res_o.l2_hit         <= l2hit_q;
      res_o.l1_evicted     <= l1ev_q;
      res_o.l2_evicted     <= l2ev_q;
      res_o.fit_error      <= fit_q;
      res_o.l1_set_index   <= sp.set1;
      res_o.l2_set_index   <= sp.set2;
      res_o.store_part     <= (op_q == OP_STORE) || ((op_q == OP_MODIFY) && part_q);
      res_o.last_of_access <= fit_q || (op_q != OP_MODIFY) || part_q;
    end
  end

  assign res_o.valid = res_valid_q;
endmodule

@@ hdl/tlc_checker.sv @@
`timescale 1ns / 1ps
`include "two_level_cache_fifo_tracker_macros.svh"
module tlc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic l1_hit,
  input logic l2_hit,
  input logic l1_evicted,
  input logic l2_evicted,
  input logic fit_error,
  input logic store_part,
  input logic last_of_access
);
  `TLC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready)
  `TLC_ASSERT_NOW(a_fit_quiet, clk_i, rst_ni, out_valid && fit_error, !l1_hit && !l2_hit && !l1_evicted && !l2_evicted && last_of_access)
  `TLC_ASSERT_NOW(a_load_part_first, clk_i, rst_ni, out_valid && !last_of_access, !store_part && !fit_error)
  `TLC_ASSERT_NOW(a_evict_on_miss, clk_i, rst_ni, out_valid, !(l1_hit && l1_evicted) && !(l2_hit && l2_evicted))
endmodule

bind two_level_cache_fifo_tracker tlc_checker u_tlc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid      (acc_i.valid),
  .in_ready      (acc_i.ready),
  .out_valid     (res_o.valid),
  .l1_hit        (res_o.l1_hit),
  .l2_hit        (res_o.l2_hit),
  .l1_evicted    (res_o.l1_evicted),
  .l2_evicted    (res_o.l2_evicted),
  .fit_error     (res_o.fit_error),
  .store_part    (res_o.store_part),
  .last_of_access(res_o.last_of_access)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import tlc_pkg::*;

  localparam int CACHE_I  = 0;
  localparam int CACHE_D  = 1;
  localparam int CACHE_L2 = 2;
  localparam int IDLE_LIMIT = 20000;  // covers the clearing pass after reset
  localparam int DRAIN_CYCLES = 128;  // two parts of a modify at the widest ways

  typedef struct packed {
    bit       l1_hit;
    bit       l2_hit;
    bit       l1_evicted;
    bit       l2_evicted;
    bit       fit_error;
    bit [5:0] l1_set;
    bit [7:0] l2_set;
    bit       store_part;
    bit       last;
  } outcome_t;

  typedef struct packed {
    bit [1:0]  op;
    bit [31:0] address;
    bit [6:0]  size;
    bit        typed;
    outcome_t  want;
  } access_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = CFG_L1_SET_BITS;
  logic [4:0] cfg_wdata_i = '0;

  tlc_in_if  acc ();
  tlc_out_if res ();

  two_level_cache_fifo_tracker u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc.sink),
    .res_o       (res.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mirror of the tag stores: index by cache, set, way
  bit       line_valid [3][256][16];
  bit [31:0] line_tag  [3][256][16];
  int       fifo_ptr   [3][256];

  // Raw register values, clamped at use
  bit [2:0] reg_s1 = 3'd2;
  bit [3:0] reg_e1 = 4'd2;
  bit [2:0] reg_b1 = 3'd4;
  bit [3:0] reg_s2 = 4'd4;
  bit [4:0] reg_e2 = 5'd4;
  bit [2:0] reg_b2 = 3'd4;

  outcome_t pending_outcomes[$];
  int  fail_count = 0;
  bit  no_idle = 1'b0;
  bit  beat_seen;

  function automatic int sat(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int lookup_way(int c, int set, int ways, bit [31:0] tag);
    for (int w = 0; w < ways; w++)
      if (line_valid[c][set][w] && line_tag[c][set][w] == tag) return w;
    return -1;
  endfunction

  // Allocate a line: lowest free way, else the FIFO pointer; report a replacement
  function automatic bit allocate_line(int c, int set, int ways, bit [31:0] tag);
    int pick;
    bit was_valid;
    pick = ways;
    for (int w = 0; w < ways; w++)
      if (!line_valid[c][set][w]) begin
        pick = w;
        break;
      end
    if (pick == ways) begin
      pick = fifo_ptr[c][set];
      if (pick >= ways) pick = 0;
    end
    was_valid = line_valid[c][set][pick];
    line_valid[c][set][pick] = 1'b1;
    line_tag[c][set][pick] = tag;
    fifo_ptr[c][set] = (pick + 1 >= ways) ? 0 : pick + 1;
    return was_valid;
  endfunction

  // Work out the outcomes of one access and advance the mirrored state
  function automatic void predict_access(bit [1:0] op, bit [31:0] addr, bit [6:0] size,
                                         ref outcome_t outs[$]);
    int s1, e1, b1, s2, e2, b2, set1, set2, c, w1, w2, parts;
    bit [31:0] tag1, tag2;
    longint off1, off2;
    outcome_t o;
    s1 = sat(reg_s1, 0, 6);  e1 = sat(reg_e1, 1, 8);  b1 = sat(reg_b1, 0, 6);
    s2 = sat(reg_s2, 0, 8);  e2 = sat(reg_e2, 1, 16); b2 = sat(reg_b2, 0, 6);
    set1 = (addr >> b1) & ((1 << s1) - 1);
    set2 = (addr >> b2) & ((1 << s2) - 1);
    tag1 = addr >> (s1 + b1);
    tag2 = addr >> (s2 + b2);
    off1 = addr & ((1 << b1) - 1);
    off2 = addr & ((1 << b2) - 1);
    o = '0;
    o.l1_set = 6'(set1);
    o.l2_set = 8'(set2);
    if (off1 + size > (1 << b1) || off2 + size > (1 << b2)) begin
      o.fit_error = 1'b1;
      o.store_part = (op == OP_STORE);
      o.last = 1'b1;
      outs.push_back(o);
      return;
    end
    c = (op == OP_FETCH) ? CACHE_I : CACHE_D;
    parts = (op == OP_MODIFY) ? 2 : 1;
    for (int k = 0; k < parts; k++) begin
      w1 = lookup_way(c, set1, e1, tag1);
      w2 = lookup_way(CACHE_L2, set2, e2, tag2);
      o.l1_hit = (w1 >= 0);
      o.l2_hit = (w2 >= 0);
      o.l2_evicted = (w2 < 0) ? allocate_line(CACHE_L2, set2, e2, tag2) : 1'b0;
      o.l1_evicted = (w1 < 0) ? allocate_line(c, set1, e1, tag1) : 1'b0;
      o.store_part = (op == OP_STORE) || (op == OP_MODIFY && k == 1);
      o.last = (k == parts - 1);
      outs.push_back(o);
    end
  endfunction

  // Directed beats after reset: hits, misses, evictions, boundary crossings, size 0
  localparam int N_ROWS = 20;
  access_row_t directed_rows[N_ROWS] = '{
    '{OP_FETCH,  32'h0000_0000, 7'd1,   1'b1, '{0, 0, 0, 0, 0, 6'd0, 8'd0, 0, 1}},
    '{OP_FETCH,  32'h0000_0000, 7'd1,   1'b1, '{1, 1, 0, 0, 0, 6'd0, 8'd0, 0, 1}},
    '{OP_LOAD,   32'h0000_0000, 7'd16,  1'b1, '{0, 1, 0, 0, 0, 6'd0, 8'd0, 0, 1}},
    '{OP_STORE,  32'h0000_0010, 7'd1,   1'b1, '{0, 0, 0, 0, 0, 6'd1, 8'd1, 1, 1}},
    '{OP_MODIFY, 32'h0000_0020, 7'd4,   1'b0, '0},
    '{OP_FETCH,  32'h0000_000F, 7'd2,   1'b1, '{0, 0, 0, 0, 1, 6'd0, 8'd0, 0, 1}},
    '{OP_STORE,  32'h0000_001F, 7'd127, 1'b1, '{0, 0, 0, 0, 1, 6'd1, 8'd1, 1, 1}},
    '{OP_LOAD,   32'h0000_0000, 7'd0,   1'b1, '{1, 1, 0, 0, 0, 6'd0, 8'd0, 0, 1}},
    '{OP_LOAD,   32'hFFFF_FFFF, 7'd1,   1'b1, '{0, 0, 0, 0, 0, 6'd3, 8'd15, 0, 1}},
    '{OP_MODIFY, 32'hFFFF_FFF0, 7'd16,  1'b0, '0},
    '{OP_MODIFY, 32'h0000_0040, 7'd17,  1'b1, '{0, 0, 0, 0, 1, 6'd0, 8'd4, 0, 1}},
    '{OP_LOAD,   32'h0000_0040, 7'd8,   1'b0, '0},
    '{OP_LOAD,   32'h0000_0080, 7'd8,   1'b0, '0},
    '{OP_STORE,  32'h0000_00C0, 7'd8,   1'b0, '0},
    '{OP_FETCH,  32'h0000_0100, 7'd4,   1'b0, '0},
    '{OP_FETCH,  32'h0000_0200, 7'd4,   1'b0, '0},
    '{OP_FETCH,  32'h0000_0300, 7'd4,   1'b0, '0},
    '{OP_FETCH,  32'h0000_0400, 7'd4,   1'b0, '0},
    '{OP_FETCH,  32'h0000_0500, 7'd4,   1'b0, '0},
    '{OP_MODIFY, 32'h0000_0100, 7'd64,  1'b1, '{0, 0, 0, 0, 1, 6'd0, 8'd0, 0, 1}}
  };

  task automatic drive_beat(bit [1:0] op, bit [31:0] addr, bit [6:0] size, bit typed,
                            outcome_t want);
    outcome_t outs[$];
    // Drop valid for a random burst now and then
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      acc.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    acc.valid <= 1'b1;
    acc.op <= op;
    acc.address <= addr;
    acc.access_size <= size;
    @(posedge clk_i);
    while (!acc.ready) @(posedge clk_i);
    predict_access(op, addr, size, outs);
    if (typed) pending_outcomes.push_back(want);
    else foreach (outs[i]) pending_outcomes.push_back(outs[i]);
  endtask

  // Hold the sender until every result is back, then let the block go quiet
  task automatic drain();
    acc.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One write per call; drop the enable before the next write
  task automatic write_reg(logic [2:0] idx, logic [4:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_L1_SET_BITS:   reg_s1 = val[2:0];
      CFG_L1_WAYS:       reg_e1 = val[3:0];
      CFG_L1_BLOCK_BITS: reg_b1 = val[2:0];
      CFG_L2_SET_BITS:   reg_s2 = val[3:0];
      CFG_L2_WAYS:       reg_e2 = val[4:0];
      default:           reg_b2 = val[2:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic random_phase(int n_beats);
    bit [31:0] hot[24];
    bit [31:0] addr;
    bit [6:0]  size;
    int blk;
    foreach (hot[i]) hot[i] = $urandom();
    blk = 1 << sat(reg_b1 < reg_b2 ? reg_b1 : reg_b2, 0, 6);
    for (int n = 0; n < n_beats; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any address, any size, mostly crossing a line
        addr = $urandom();
        size = 7'($urandom_range(0, 127));
      end else begin
        addr = hot[$urandom_range(0, 23)] ^ ($urandom() & (blk - 1));
        size = 7'($urandom_range(1, blk - (addr & (blk - 1))));
      end
      drive_beat(2'($urandom_range(0, 3)), addr, size, 1'b0, '0);
    end
  endtask

  // Result side: random stall bursts on ready unless no_idle, check each beat in order
  initial begin
    int stall;
    outcome_t got, want;
    res.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (res.valid && res.ready) begin
        got = '{res.l1_hit, res.l2_hit, res.l1_evicted, res.l2_evicted, res.fit_error,
                res.l1_set_index, res.l2_set_index, res.store_part, res.last_of_access};
        if (pending_outcomes.size() == 0) begin
          $error("unexpected result beat");
          fail_count++;
        end else begin
          want = pending_outcomes.pop_front();
          if (got.l1_hit != want.l1_hit) begin
            $error("l1_hit exp %0d got %0d", want.l1_hit, got.l1_hit); fail_count++;
          end
          if (got.l2_hit != want.l2_hit) begin
            $error("l2_hit exp %0d got %0d", want.l2_hit, got.l2_hit); fail_count++;
          end
          if (got.l1_evicted != want.l1_evicted) begin
            $error("l1_evicted exp %0d got %0d", want.l1_evicted, got.l1_evicted);
            fail_count++;
          end
          if (got.l2_evicted != want.l2_evicted) begin
            $error("l2_evicted exp %0d got %0d", want.l2_evicted, got.l2_evicted);
            fail_count++;
          end
          if (got.fit_error != want.fit_error) begin
            $error("fit_error exp %0d got %0d", want.fit_error, got.fit_error); fail_count++;
          end
          if (got.l1_set != want.l1_set) begin
            $error("l1_set_index exp %0d got %0d", want.l1_set, got.l1_set); fail_count++;
          end
          if (got.l2_set != want.l2_set) begin
            $error("l2_set_index exp %0d got %0d", want.l2_set, got.l2_set); fail_count++;
          end
          if (got.store_part != want.store_part) begin
            $error("store_part exp %0d got %0d", want.store_part, got.store_part);
            fail_count++;
          end
          if (got.last != want.last) begin
            $error("last_of_access exp %0d got %0d", want.last, got.last); fail_count++;
          end
        end
      end
      if (no_idle) res.ready <= 1'b1;
      else if (stall > 0) begin
        stall--;
        res.ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 13) - 1;
        res.ready <= 1'b0;
      end else res.ready <= 1'b1;
    end
  end

  // Watchdog: count cycles with no beat on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      beat_seen = (acc.valid && acc.ready) || (res.valid && res.ready);
      quiet = beat_seen ? 0 : quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    acc.valid = 1'b0;
    acc.op = OP_FETCH;
    acc.address = '0;
    acc.access_size = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      drive_beat(directed_rows[i].op, directed_rows[i].address, directed_rows[i].size,
                 directed_rows[i].typed, directed_rows[i].want);
    drain();

    // Smallest geometry
    write_reg(CFG_L1_SET_BITS, 5'd0);   write_reg(CFG_L1_WAYS, 5'd1);
    write_reg(CFG_L1_BLOCK_BITS, 5'd0); write_reg(CFG_L2_SET_BITS, 5'd0);
    write_reg(CFG_L2_WAYS, 5'd1);       write_reg(CFG_L2_BLOCK_BITS, 5'd0);
    random_phase(250);
    drain();

    // Largest legal geometry
    write_reg(CFG_L1_SET_BITS, 5'd6);   write_reg(CFG_L1_WAYS, 5'd8);
    write_reg(CFG_L1_BLOCK_BITS, 5'd6); write_reg(CFG_L2_SET_BITS, 5'd8);
    write_reg(CFG_L2_WAYS, 5'd16);      write_reg(CFG_L2_BLOCK_BITS, 5'd6);
    random_phase(300);
    drain();

    // Out of range values saturate
    write_reg(CFG_L1_SET_BITS, 5'd7);   write_reg(CFG_L1_WAYS, 5'd15);
    write_reg(CFG_L1_BLOCK_BITS, 5'd7); write_reg(CFG_L2_SET_BITS, 5'd15);
    write_reg(CFG_L2_WAYS, 5'd31);      write_reg(CFG_L2_BLOCK_BITS, 5'd7);
    random_phase(250);
    drain();

    // Zero ways count as one
    write_reg(CFG_L1_WAYS, 5'd0);
    write_reg(CFG_L2_WAYS, 5'd0);
    write_reg(CFG_L1_SET_BITS, 5'd3);
    write_reg(CFG_L2_BLOCK_BITS, 5'd2);
    random_phase(250);
    drain();

    // Random geometries; the stale tags stay in place across writes
    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_L1_SET_BITS, 5'($urandom_range(0, 7)));
      write_reg(CFG_L1_WAYS, 5'($urandom_range(0, 15)));
      write_reg(CFG_L1_BLOCK_BITS, 5'($urandom_range(0, 7)));
      write_reg(CFG_L2_SET_BITS, 5'($urandom_range(0, 15)));
      write_reg(CFG_L2_WAYS, 5'($urandom_range(0, 31)));
      write_reg(CFG_L2_BLOCK_BITS, 5'($urandom_range(0, 7)));
      if (p == 2) no_idle = 1'b1;
      random_phase(300);
      drain();
    end

    if (pending_outcomes.size() != 0) begin
      $error("%0d results never arrived", pending_outcomes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
